### hdl/rwct_pkg.sv
// Shared types, constants and helpers for the raycast wall column texel core.
package rwct_pkg;

  // Default tile edge in pixels
  localparam int TILE_PIXELS_DEF = 64;

  // Field widths
  localparam int ROW_W      = 12;
  localparam int TEX_SIZE_W = 11;
  localparam int TEX_IDX_W  = 10;
  localparam int ADDR_W     = 20;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Strip height is 29.16 and saturates at 2^44
  localparam int              STRIP_W   = 45;
  localparam logic [STRIP_W-1:0] STRIP_MAX = STRIP_W'(1) << 44;

  // Register reset values
  localparam logic [ROW_W-1:0]      SCREEN_HEIGHT_RST = 12'd1024;
  localparam logic [31:0]           PROJ_DISTANCE_RST = 32'd58118145;
  localparam logic [TEX_SIZE_W-1:0] TEX_SIZE_RST      = 11'd64;
  localparam logic [TEX_SIZE_W-1:0] TEX_SIZE_MAX      = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_HEIGHT = 3'd0,
    CFG_PROJ_DISTANCE = 3'd1,
    CFG_TEX_WIDTH     = 3'd2,
    CFG_TEX_HEIGHT    = 3'd3,
    CFG_CEILING_COLOR = 3'd4,
    CFG_FLOOR_COLOR   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_CEILING = 2'd0,
    KIND_FLOOR   = 2'd1,
    KIND_WALL    = 2'd2
  } pixel_kind_e;

  typedef enum logic [1:0] {
    TEX_NORTH = 2'd0,
    TEX_SOUTH = 2'd1,
    TEX_WEST  = 2'd2,
    TEX_EAST  = 2'd3
  } tex_sel_e;

  // Clamp a texture size to 1..1024
  function automatic logic [TEX_SIZE_W-1:0] clamp_size(input logic [TEX_SIZE_W-1:0] v);
    logic [TEX_SIZE_W-1:0] r;
    if (v == '0) begin
      r = TEX_SIZE_W'(1);
    end else if (v > TEX_SIZE_MAX) begin
      r = TEX_SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/rwct_if.sv
// Valid/ready channel interfaces for pixel items in and texel results out.
interface rwct_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] ray_distance;
  logic [31:0] hit_coord;
  logic        hit_horizontal;
  logic [15:0] ray_angle;
  logic [11:0] row;

  modport source (output valid, ray_distance, hit_coord, hit_horizontal, ray_angle, row,
                  input ready);
  modport sink (input valid, ray_distance, hit_coord, hit_horizontal, ray_angle, row,
                output ready);
endinterface

interface rwct_texel_if;
  logic        valid;
  logic        ready;
  logic [1:0]  pixel_kind;
  logic [23:0] flat_color;
  logic [1:0]  texture_select;
  logic [9:0]  tex_x;
  logic [9:0]  tex_y;
  logic [19:0] texel_address;

  modport source (output valid, pixel_kind, flat_color, texture_select, tex_x, tex_y,
                  texel_address, input ready);
  modport sink (input valid, pixel_kind, flat_color, texture_select, tex_x, tex_y,
                texel_address, output ready);
endinterface

### hdl/rwct_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband that rides along.
module rwct_div #(
  parameter int VW = 32,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [VW+QW-1:0] dividend_i,  // upper VW bits must be below divisor_i
  input  logic [VW-1:0]    divisor_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_o,
  output logic [VW-1:0]    rem_o,
  output logic [SW-1:0]    side_o
);

  logic [VW-1:0] r_q    [QW];
  logic [QW-1:0] dq_q   [QW];
  logic [VW-1:0] d_q    [QW];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [VW-1:0] r_src;
    logic [QW-1:0] dq_src;
    logic [VW-1:0] d_src;
    logic [SW-1:0] side_src;
    logic          vld_src;
    logic [VW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_src    = dividend_i[VW+QW-1:QW];
      assign dq_src   = dividend_i[QW-1:0];
      assign d_src    = divisor_i;
      assign side_src = side_i;
      assign vld_src  = valid_i;
    end else begin : g_next
      assign r_src    = r_q[k-1];
      assign dq_src   = dq_q[k-1];
      assign d_src    = d_q[k-1];
      assign side_src = side_q[k-1];
      assign vld_src  = vld_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign t  = {r_src, dq_src[QW-1]};
    assign ge = (t >= {1'b0, d_src});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? VW'(t - {1'b0, d_src}) : t[VW-1:0];
        dq_q[k]   <= {dq_src[QW-2:0], ge};
        d_q[k]    <= d_src;
        side_q[k] <= side_src;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = dq_q[QW-1];
  assign rem_o   = r_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

### hdl/raycast_wall_column_texel_core.sv
// Top level: textured raycaster wall column, one screen pixel in, one texel result out.
// Pipeline: from input transfer to result valid lie the pipelined dividers
//   (strip height 45 stages, texel row 11) and eleven single register stages.
// Throughput: one pixel per cycle; a stalled output holds the whole pipeline in place.
// Reset: asynchronous active low; clears all valid bits and loads register defaults.
module raycast_wall_column_texel_core
  import rwct_pkg::*;
#(
  parameter int TILE_PIXELS = TILE_PIXELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rwct_pix_if.sink              pix_i,
  rwct_texel_if.source          texel_o
);

  localparam int TILE_W = $clog2(TILE_PIXELS + 1);
  localparam int TILE_L = $clog2(TILE_PIXELS);
  localparam int PW     = 32 + TILE_W;
  localparam int MW     = TILE_W + 16;
  localparam int XW     = MW + TEX_SIZE_W;
  localparam int YW     = STRIP_W + TEX_SIZE_W;
  localparam int NW     = TILE_W + TEX_SIZE_W;
  localparam int RM_W   = 17;
  localparam int RX_W   = NW + 1;
  localparam int TP_W   = 16 + RM_W;
  localparam int XP_W   = NW + RX_W;

  // Reciprocals of the tile size rounded up; exact quotients for every numerator of the width
  localparam logic [63:0] RCP_M64 =
    ((64'd1 << (16 + TILE_L)) + 64'(TILE_PIXELS - 1)) / 64'(TILE_PIXELS);
  localparam logic [63:0] RCP_X64 =
    ((64'd1 << (NW + TILE_L)) + 64'(TILE_PIXELS - 1)) / 64'(TILE_PIXELS);
  localparam logic [RM_W-1:0] RCP_M = RM_W'(RCP_M64);
  localparam logic [RX_W-1:0] RCP_X = RX_W'(RCP_X64);

  typedef struct packed {
    logic [31:0]      hit;
    tex_sel_e         sel;
    logic [ROW_W-1:0] row;
    logic             sat;
  } s_side_t;

  typedef struct packed {
    logic [31:0] hit;
    tex_sel_e    sel;
    pixel_kind_e kind;
    logic        sat;
  } y_side_t;

  typedef struct packed {
    logic [15:0]          lo;
    tex_sel_e             sel;
    pixel_kind_e          kind;
    logic [TEX_IDX_W-1:0] ty;
  } m_side_t;

  typedef struct packed {
    tex_sel_e             sel;
    pixel_kind_e          kind;
    logic [TEX_IDX_W-1:0] ty;
  } x_side_t;

  // Configuration registers
  logic [ROW_W-1:0]      scr_h_q;
  logic [31:0]           proj_q;
  logic [TEX_SIZE_W-1:0] tex_w_q;
  logic [TEX_SIZE_W-1:0] tex_h_q;
  logic [COLOR_W-1:0]    ceil_col_q;
  logic [COLOR_W-1:0]    floor_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_h_q     <= SCREEN_HEIGHT_RST;
      proj_q      <= PROJ_DISTANCE_RST;
      tex_w_q     <= TEX_SIZE_RST;
      tex_h_q     <= TEX_SIZE_RST;
      ceil_col_q  <= '0;
      floor_col_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_HEIGHT: scr_h_q     <= cfg_data_i[ROW_W-1:0];
        CFG_PROJ_DISTANCE: proj_q      <= cfg_data_i;
        CFG_TEX_WIDTH:     tex_w_q     <= cfg_data_i[TEX_SIZE_W-1:0];
        CFG_TEX_HEIGHT:    tex_h_q     <= cfg_data_i[TEX_SIZE_W-1:0];
        CFG_CEILING_COLOR: ceil_col_q  <= cfg_data_i[COLOR_W-1:0];
        CFG_FLOOR_COLOR:   floor_col_q <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [TEX_SIZE_W-1:0] tw;
  logic [TEX_SIZE_W-1:0] th;
  assign tw = clamp_size(tex_w_q);
  assign th = clamp_size(tex_h_q);

  // Global advance: move when the output register is empty or being drained
  logic out_vld_q;
  logic en;
  assign en          = !out_vld_q || texel_o.ready;
  assign pix_i.ready = en;

  // Stage 1: tile times projection distance, texture side
  logic             s1_vld_q;
  logic [PW-1:0]    s1_prod_q;
  logic [31:0]      s1_dist_q;
  logic [31:0]      s1_hit_q;
  tex_sel_e         s1_sel_q;
  logic [ROW_W-1:0] s1_row_q;

  logic [31:0] dist_fix;
  logic [31:0] pd_fix;
  tex_sel_e    sel_in;

  always_comb begin
    dist_fix = (pix_i.ray_distance == '0) ? 32'd1 : pix_i.ray_distance;
    pd_fix   = (proj_q == '0) ? 32'd1 : proj_q;
    if (pix_i.hit_horizontal) begin
      sel_in = pix_i.ray_angle[15] ? TEX_NORTH : TEX_SOUTH;
    end else if (pix_i.ray_angle >= 16'd16384 && pix_i.ray_angle <= 16'd49152) begin
      sel_in = TEX_WEST;
    end else begin
      sel_in = TEX_EAST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= PW'(TILE_PIXELS) * PW'(pd_fix);
      s1_dist_q <= dist_fix;
      s1_hit_q  <= pix_i.hit_coord;
      s1_sel_q  <= sel_in;
      s1_row_q  <= pix_i.row;
    end
  end

  // Strip height division: quotient of 45 bits, larger values saturate
  logic [63:0]              num64;
  logic [63:0]              num_hi;
  logic                     s_sat;
  logic [32+STRIP_W-1:0]    ds_dividend;
  s_side_t                  ds_side_in;
  s_side_t                  ds_side_out;
  logic                     ds_vld;
  logic [STRIP_W-1:0]       ds_quot;

  always_comb begin
    num64       = 64'(s1_prod_q) << 16;
    num_hi      = num64 >> STRIP_W;
    s_sat       = (num_hi >= 64'(s1_dist_q));
    ds_dividend = {s_sat ? 32'd0 : num_hi[31:0], num64[STRIP_W-1:0]};
    ds_side_in  = '{hit: s1_hit_q, sel: s1_sel_q, row: s1_row_q, sat: s_sat};
  end

  rwct_div #(
    .VW (32),
    .QW (STRIP_W),
    .SW ($bits(s_side_t))
  ) u_div_strip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s1_vld_q),
    .dividend_i (ds_dividend),
    .divisor_i  (s1_dist_q),
    .side_i     (ds_side_in),
    .valid_o    (ds_vld),
    .quot_o     (ds_quot),
    .rem_o      (),
    .side_o     (ds_side_out)
  );

  // Stage 2: saturated strip height
  logic               s2_vld_q;
  logic [STRIP_W-1:0] s2_s_q;
  logic [31:0]        s2_hit_q;
  tex_sel_e           s2_sel_q;
  logic [ROW_W-1:0]   s2_row_q;

  // Stage 3: ceiling edge and scaled row position
  logic               s3_vld_q;
  logic [STRIP_W-1:0] s3_s_q;
  logic [ROW_W-1:0]   s3_c_q;
  logic [STRIP_W-1:0] s3_a_q;
  logic [31:0]        s3_hit_q;
  tex_sel_e           s3_sel_q;
  logic [ROW_W-1:0]   s3_row_q;

  // Stage 4: row class and offset into the strip
  logic               s4_vld_q;
  pixel_kind_e        s4_kind_q;
  logic [STRIP_W-1:0] s4_tmp_q;
  logic [STRIP_W-1:0] s4_s_q;
  logic [31:0]        s4_hit_q;
  tex_sel_e           s4_sel_q;

  // Stage 5: offset times texture height
  logic               s5_vld_q;
  logic [YW-1:0]      s5_ymul_q;
  logic [STRIP_W-1:0] s5_sdiv_q;
  pixel_kind_e        s5_kind_q;
  logic [31:0]        s5_hit_q;
  tex_sel_e           s5_sel_q;

  logic [STRIP_W-1:0] hfx;
  logic [STRIP_W-1:0] half_h;
  logic [ROW_W-1:0]   c_edge;
  pixel_kind_e        kind_c;

  always_comb begin
    hfx    = STRIP_W'({scr_h_q, 16'd0});
    c_edge = (s2_s_q >= hfx) ? '0 : ROW_W'((hfx - s2_s_q) >> 17);
    half_h = STRIP_W'({scr_h_q[ROW_W-1:1], 16'd0});
    if (s3_row_q >= scr_h_q || s3_row_q >= (scr_h_q - s3_c_q)) begin
      kind_c = KIND_FLOOR;
    end else if (s3_row_q < s3_c_q) begin
      kind_c = KIND_CEILING;
    end else begin
      kind_c = KIND_WALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= ds_vld;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_s_q    <= (ds_side_out.sat || ds_quot > STRIP_MAX) ? STRIP_MAX : ds_quot;
      s2_hit_q  <= ds_side_out.hit;
      s2_sel_q  <= ds_side_out.sel;
      s2_row_q  <= ds_side_out.row;

      s3_s_q    <= s2_s_q;
      s3_c_q    <= c_edge;
      s3_a_q    <= STRIP_W'({s2_row_q, 16'd0}) + {1'b0, s2_s_q[STRIP_W-1:1]};
      s3_hit_q  <= s2_hit_q;
      s3_sel_q  <= s2_sel_q;
      s3_row_q  <= s2_row_q;

      s4_kind_q <= kind_c;
      s4_tmp_q  <= (s3_a_q > half_h) ? (s3_a_q - half_h) : '0;
      s4_s_q    <= s3_s_q;
      s4_hit_q  <= s3_hit_q;
      s4_sel_q  <= s3_sel_q;

      s5_ymul_q <= YW'(s4_tmp_q) * YW'(th);
      s5_sdiv_q <= (s4_s_q == '0) ? STRIP_W'(1) : s4_s_q;
      s5_kind_q <= s4_kind_q;
      s5_hit_q  <= s4_hit_q;
      s5_sel_q  <= s4_sel_q;
    end
  end

  // Texel row division: 11 quotient bits, larger values clamp
  logic                    y_sat;
  logic [YW-1:0]           dy_dividend;
  y_side_t                 dy_side_in;
  y_side_t                 dy_side_out;
  logic                    dy_vld;
  logic [TEX_SIZE_W-1:0]   dy_quot;

  always_comb begin
    y_sat       = (s5_ymul_q[YW-1:TEX_SIZE_W] >= s5_sdiv_q);
    dy_dividend = {y_sat ? '0 : s5_ymul_q[YW-1:TEX_SIZE_W], s5_ymul_q[TEX_SIZE_W-1:0]};
    dy_side_in  = '{hit: s5_hit_q, sel: s5_sel_q, kind: s5_kind_q, sat: y_sat};
  end

  rwct_div #(
    .VW (STRIP_W),
    .QW (TEX_SIZE_W),
    .SW ($bits(y_side_t))
  ) u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s5_vld_q),
    .dividend_i (dy_dividend),
    .divisor_i  (s5_sdiv_q),
    .side_i     (dy_side_in),
    .valid_o    (dy_vld),
    .quot_o     (dy_quot),
    .rem_o      (),
    .side_o     (dy_side_out)
  );

  // Stage 6: clamped texel row
  logic                 s6_vld_q;
  logic [TEX_IDX_W-1:0] s6_ty_q;
  logic [31:0]          s6_hit_q;
  tex_sel_e             s6_sel_q;
  pixel_kind_e          s6_kind_q;

  logic [TEX_SIZE_W-1:0] th_max;
  assign th_max = th - TEX_SIZE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= dy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_ty_q   <= TEX_IDX_W'((dy_side_out.sat || dy_quot > th_max) ? th_max : dy_quot);
      s6_hit_q  <= dy_side_out.hit;
      s6_sel_q  <= dy_side_out.sel;
      s6_kind_q <= dy_side_out.kind;
    end
  end

  // Tile fraction: whole part of the hit coordinate modulo the tile size, by reciprocal multiply

  // Stage 7: whole tiles in the hit coordinate
  logic        s7_vld_q;
  logic [15:0] s7_whole_q;
  logic [15:0] s7_quot_q;
  m_side_t     s7_side_q;

  // Stage 8: offset into the tile
  logic              s8_vld_q;
  logic [TILE_W-1:0] s8_rem_q;
  m_side_t           s8_side_q;

  // Stage 9: fraction times texture width
  logic          s9_vld_q;
  logic [XW-1:0] s9_xmul_q;
  x_side_t       s9_side_q;

  // Stage 10: texel column, the scaled fraction over the tile size
  logic                  s10_vld_q;
  logic [TEX_SIZE_W-1:0] s10_tx_q;
  x_side_t               s10_side_q;

  m_side_t         s6_side;
  logic [TP_W-1:0] tile_prod;
  logic [15:0]     tile_back;
  logic [XP_W-1:0] col_prod;

  assign s6_side   = '{lo: s6_hit_q[15:0], sel: s6_sel_q, kind: s6_kind_q, ty: s6_ty_q};
  assign tile_prod = TP_W'(s6_hit_q[31:16]) * TP_W'(RCP_M);
  assign tile_back = 16'(32'(s7_quot_q) * 32'(TILE_PIXELS));
  assign col_prod  = XP_W'(s9_xmul_q[XW-1:16]) * XP_W'(RCP_X);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_whole_q <= s6_hit_q[31:16];
      s7_quot_q  <= 16'(tile_prod >> (16 + TILE_L));
      s7_side_q  <= s6_side;

      s8_rem_q   <= TILE_W'(s7_whole_q - tile_back);
      s8_side_q  <= s7_side_q;

      s9_xmul_q  <= XW'({s8_rem_q, s8_side_q.lo}) * XW'(tw);
      s9_side_q  <= '{sel: s8_side_q.sel, kind: s8_side_q.kind, ty: s8_side_q.ty};

      s10_tx_q   <= TEX_SIZE_W'(col_prod >> (NW + TILE_L));
      s10_side_q <= s9_side_q;
    end
  end

  // Output register
  pixel_kind_e          out_kind_q;
  logic [COLOR_W-1:0]   out_color_q;
  tex_sel_e             out_sel_q;
  logic [TEX_IDX_W-1:0] out_tx_q;
  logic [TEX_IDX_W-1:0] out_ty_q;
  logic [ADDR_W-1:0]    out_addr_q;

  logic [TEX_SIZE_W-1:0] tw_max;
  logic [TEX_IDX_W-1:0]  tx_c;
  logic [ADDR_W-1:0]     addr_c;
  logic                  wall_c;

  always_comb begin
    tw_max = tw - TEX_SIZE_W'(1);
    tx_c   = TEX_IDX_W'((s10_tx_q > tw_max) ? tw_max : s10_tx_q);
    addr_c = ADDR_W'(21'(tw) * 21'(s10_side_q.ty)) + ADDR_W'(tx_c);
    wall_c = (s10_side_q.kind == KIND_WALL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s10_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_kind_q <= s10_side_q.kind;
      unique case (s10_side_q.kind)
        KIND_CEILING: out_color_q <= ceil_col_q;
        KIND_FLOOR:   out_color_q <= floor_col_q;
        default:      out_color_q <= '0;
      endcase
      out_sel_q  <= wall_c ? s10_side_q.sel : TEX_NORTH;
      out_tx_q   <= wall_c ? tx_c : '0;
      out_ty_q   <= wall_c ? s10_side_q.ty : '0;
      out_addr_q <= wall_c ? addr_c : '0;
    end
  end

  assign texel_o.valid          = out_vld_q;
  assign texel_o.pixel_kind     = out_kind_q;
  assign texel_o.flat_color     = out_color_q;
  assign texel_o.texture_select = out_sel_q;
  assign texel_o.tex_x          = out_tx_q;
  assign texel_o.tex_y          = out_ty_q;
  assign texel_o.texel_address  = out_addr_q;

endmodule
